>>> sv/tcsgr_pkg.sv
`default_nettype none
package tcsgr_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;
	localparam int DEF_TAB     = 8;
	localparam int DEF_ESC     = 64;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_ERASE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [15:0] ATTR_DEFAULT = 16'h0700;
	localparam logic [15:0] ATTR_BRIGHT  = 16'h0800;
	localparam logic [15:0] FG_KEEP      = 16'hF8FF;
	localparam logic [15:0] BG_KEEP      = 16'h0FFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic       bypass_escape;
		logic       erase_twice;
		logic [4:0] query_row;
		logic [6:0] query_column;
	} req_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic [15:0] attribute_word;
		logic        escape_pending;
		logic [15:0] cell_value;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] attr;
	} sgr_res_t;

	function automatic logic [3:0] colour_map(input logic [2:0] idx);
		logic [3:0] v;
		unique case (idx)
			3'd0: v = 4'h0;
			3'd1: v = 4'h4;
			3'd2: v = 4'h2;
			3'd3: v = 4'hE;
			3'd4: v = 4'h1;
			3'd5: v = 4'h5;
			3'd6: v = 4'h3;
			default: v = 4'hF;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> sv/tcsgr_cell_ram.sv
`default_nettype none
module tcsgr_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);
	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> sv/tcsgr_esc_ram.sv
`default_nettype none
module tcsgr_esc_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> sv/tcsgr_sgr_decode.sv
`default_nettype none
module tcsgr_sgr_decode #(
	parameter int CNT_W = 7
) (
	input  wire logic [CNT_W-1:0]       cnt,
	input  wire logic [7:0]             b1,
	input  wire logic [7:0]             b2,
	input  wire logic [7:0]             b3,
	input  wire logic [7:0]             b4,
	input  wire logic [15:0]            attr,
	output tcsgr_pkg::sgr_res_t         res
);
	import tcsgr_pkg::*;

	logic signed [13:0] op2;
	logic [13:0]        fg_i;
	logic [13:0]        bg_i;

	// two-digit value, bytes taken as arbitrary codes
	assign op2  = $signed({3'b000, b2, 3'b000}) + $signed({5'b00000, b2, 1'b0})
	            + $signed({6'b000000, b3}) - 14'sd528;
	assign fg_i = op2 - 14'sd30;
	assign bg_i = op2 - 14'sd40;

	always_comb begin
		res.valid = 1'b0;
		res.attr  = attr;
		if (cnt == CNT_W'(4) && b1 == CH_LBR && b3 == CH_M &&
		    (b2 == CH_ZERO || b2 == CH_ONE)) begin
			res.valid = 1'b1;
			res.attr  = (b2 == CH_ZERO) ? ATTR_DEFAULT : (attr | ATTR_BRIGHT);
		end else if (cnt == CNT_W'(5) && b1 == CH_LBR && b4 == CH_M) begin
			if (op2 >= 14'sd30 && op2 <= 14'sd37) begin
				res.valid = 1'b1;
				res.attr  = (attr & FG_KEEP) | {4'h0, colour_map(fg_i[2:0]), 8'h00};
			end else if (op2 >= 14'sd40 && op2 <= 14'sd47) begin
				res.valid = 1'b1;
				res.attr  = (attr & BG_KEEP) | {colour_map(bg_i[2:0]), 12'h000};
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/text_console_with_sgr_colour.sv
`default_nettype none
// channel   | signals             | transfer
// ----------+---------------------+-----------------------------------
// request   | start, busy, req    | accepted when start && !busy
// result    | done, rsp           | one cycle wide, taken when done
//
// A scroll walks the cell memory once through its single write port, reading each row
// below and writing it one row up. An invalid sequence replays each buffered byte as a
// character (plus any scrolls). After reset a clearing pass keeps busy high. The
// receiver cannot stall; done is one cycle.
module text_console_with_sgr_colour #(
	parameter int SCREEN_COLUMNS = tcsgr_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS    = tcsgr_pkg::DEF_ROWS,
	parameter int TAB_STOP       = tcsgr_pkg::DEF_TAB,
	parameter int ESCAPE_DEPTH   = tcsgr_pkg::DEF_ESC
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire tcsgr_pkg::req_t  req,
	output logic                  done,
	output tcsgr_pkg::rsp_t       rsp
);
	import tcsgr_pkg::*;

	localparam int CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW      = $clog2(CELLS);
	localparam int RW      = $clog2(SCREEN_ROWS + 1);
	localparam int CW      = $clog2(SCREEN_COLUMNS + TAB_STOP);
	localparam int PW      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int EAW     = $clog2(ESCAPE_DEPTH);
	localparam int ECW     = $clog2(ESCAPE_DEPTH + 1);
	localparam int LAST_PH = (SCREEN_COLUMNS - 1) % TAB_STOP;

	typedef enum logic [3:0] {
		S_IDLE, S_PCHAR, S_WRAP, S_SCROLL, S_SDRAIN, S_DRAW, S_JUDGE, S_REP_RD,
		S_REP_LD, S_REP_NEXT, S_ER_A, S_ER_B, S_CLR, S_RD, S_RD_WAIT, S_FIN
	} st_t;

	st_t             st_q;
	logic [RW-1:0]   r_q;
	logic [CW-1:0]   c_q;
	logic [PW-1:0]   ph_q;
	logic [15:0]     attr_q;
	logic            esc_q;
	logic [ECW-1:0]  cnt_q;
	logic [7:0]      b1_q, b2_q, b3_q, b4_q;
	logic [7:0]      ch_q;
	logic            byp_q;
	logic            twice_q;
	logic            rep_q;
	logic [ECW-1:0]  rep_i_q;
	logic [ECW-1:0]  rep_n_q;
	logic [AW-1:0]   k_q;
	logic [AW-1:0]   qaddr_q;
	logic [15:0]     cell_q;
	logic            quiet_q;
	logic            done_q;
	rsp_t            rsp_q;
	logic            wv_s1;
	logic            wz_s1;
	logic [AW-1:0]   wa_s1;

	logic            mwe;
	logic [AW-1:0]   mwa;
	logic [15:0]     mwd;
	logic [AW-1:0]   cur_addr;
	logic            ram_we;
	logic [AW-1:0]   ram_wa;
	logic [15:0]     ram_wd;
	logic [AW-1:0]   ram_ra;
	logic [15:0]     ram_rd;
	logic            ewe;
	logic [7:0]      erd;
	logic            feed;
	logic            printable;
	logic            ovf;
	logic [RW-1:0]   rt;
	logic [PW-1:0]   ph_inc;
	logic [PW-1:0]   ph_dec;
	sgr_res_t        dec;

	assign cur_addr = AW'(32'(r_q) * SCREEN_COLUMNS + 32'(c_q));
	assign feed     = esc_q && !byp_q;
	assign printable = !(ch_q == CH_LF || ch_q == CH_CR || ch_q == CH_TAB ||
	                     ch_q == CH_ESC || ch_q == CH_BS || ch_q == CH_DEL);
	assign ovf      = (32'(c_q) >= SCREEN_COLUMNS);
	assign rt       = r_q + RW'(ovf);
	assign ph_inc   = (32'(ph_q) == TAB_STOP - 1) ? '0 : PW'(32'(ph_q) + 1);
	assign ph_dec   = (ph_q == '0) ? PW'(TAB_STOP - 1) : PW'(32'(ph_q) - 1);

	always_comb begin
		mwe = 1'b0;
		mwa = cur_addr;
		mwd = '0;
		ewe = 1'b0;
		unique case (st_q)
			S_PCHAR: begin
				if (feed || (ch_q == CH_ESC && !esc_q)) begin
					ewe = 1'b1;
				end else if (ch_q == CH_CR) begin
					mwe = 1'b1;
				end else if (printable) begin
					mwe = 1'b1;
					mwd = attr_q | {8'h00, ch_q};
				end
			end
			S_ER_A: mwe = 1'b1;
			S_ER_B, S_DRAW: begin
				mwe = 1'b1;
				mwd = attr_q | {8'h00, CH_SPACE};
			end
			S_CLR: begin
				mwe = 1'b1;
				mwa = k_q;
			end
			default: ;
		endcase
	end

	assign ram_we = wv_s1 | mwe;
	assign ram_wa = wv_s1 ? wa_s1 : mwa;
	assign ram_wd = wv_s1 ? (wz_s1 ? 16'h0000 : ram_rd) : mwd;
	assign ram_ra = (st_q == S_SCROLL) ? AW'(32'(k_q) + SCREEN_COLUMNS) : qaddr_q;

	tcsgr_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	tcsgr_esc_ram #(.DEPTH(ESCAPE_DEPTH), .AW(EAW)) u_esc (
		.clk   (clk),
		.we    (ewe),
		.waddr (cnt_q[EAW-1:0]),
		.wdata (ch_q),
		.raddr (rep_i_q[EAW-1:0]),
		.rdata (erd)
	);

	tcsgr_sgr_decode #(.CNT_W(ECW)) u_dec (
		.cnt  (cnt_q),
		.b1   (b1_q),
		.b2   (b2_q),
		.b3   (b3_q),
		.b4   (b4_q),
		.attr (attr_q),
		.res  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLR;
			r_q     <= '0;
			c_q     <= '0;
			ph_q    <= '0;
			attr_q  <= ATTR_DEFAULT;
			esc_q   <= 1'b0;
			cnt_q   <= '0;
			rep_q   <= 1'b0;
			rep_i_q <= '0;
			rep_n_q <= '0;
			twice_q <= 1'b0;
			k_q     <= '0;
			quiet_q <= 1'b1;
			done_q  <= 1'b0;
			wv_s1   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wv_s1  <= 1'b0;
			if (ewe) begin
				if (cnt_q == ECW'(1)) b1_q <= ch_q;
				if (cnt_q == ECW'(2)) b2_q <= ch_q;
				if (cnt_q == ECW'(3)) b3_q <= ch_q;
				if (cnt_q == ECW'(4)) b4_q <= ch_q;
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						ch_q    <= req.char_code;
						byp_q   <= req.bypass_escape;
						twice_q <= req.erase_twice;
						cell_q  <= '0;
						quiet_q <= 1'b0;
						qaddr_q <= AW'(32'(req.query_row) * SCREEN_COLUMNS
						               + 32'(req.query_column));
						unique case (req.req_type)
							REQ_PUT:   st_q <= S_PCHAR;
							REQ_ERASE: st_q <= S_ER_A;
							REQ_READ: begin
								if (32'(req.query_row) < SCREEN_ROWS &&
								    32'(req.query_column) < SCREEN_COLUMNS) begin
									st_q <= S_RD;
								end else begin
									st_q <= S_FIN;
								end
							end
							default: begin
								k_q  <= '0;
								st_q <= S_CLR;
							end
						endcase
					end
				end
				S_PCHAR: begin
					if (feed) begin
						cnt_q <= cnt_q + ECW'(1);
						if (ch_q == CH_M || 32'(cnt_q) + 1 == ESCAPE_DEPTH) begin
							st_q <= S_JUDGE;
						end else begin
							st_q <= S_FIN;
						end
					end else begin
						case (ch_q)
							CH_LF: begin
								r_q  <= r_q + RW'(1);
								st_q <= S_WRAP;
							end
							CH_CR: begin
								c_q  <= '0;
								ph_q <= '0;
								st_q <= rep_q ? S_REP_NEXT : S_FIN;
							end
							CH_TAB: begin
								c_q  <= c_q + CW'(TAB_STOP) - CW'(ph_q);
								ph_q <= '0;
								st_q <= S_WRAP;
							end
							CH_ESC: begin
								if (!esc_q) begin
									esc_q <= 1'b1;
									cnt_q <= ECW'(1);
									st_q  <= rep_q ? S_REP_NEXT : S_FIN;
								end else begin
									st_q <= S_WRAP;
								end
							end
							CH_BS, CH_DEL: st_q <= rep_q ? S_REP_NEXT : S_FIN;
							default: begin
								c_q  <= c_q + CW'(1);
								ph_q <= ph_inc;
								st_q <= S_WRAP;
							end
						endcase
					end
				end
				S_WRAP: begin
					if (ovf) begin
						c_q  <= '0;
						ph_q <= '0;
					end
					if (32'(rt) >= SCREEN_ROWS) begin
						r_q  <= RW'(SCREEN_ROWS - 1);
						k_q  <= '0;
						st_q <= S_SCROLL;
					end else begin
						r_q  <= rt;
						st_q <= S_DRAW;
					end
				end
				S_SCROLL: begin
					// row below is read now and written in the next cycle
					wv_s1 <= 1'b1;
					wa_s1 <= k_q;
					wz_s1 <= (32'(k_q) >= CELLS - SCREEN_COLUMNS);
					if (32'(k_q) == CELLS - 1) begin
						st_q <= S_SDRAIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_SDRAIN: st_q <= S_DRAW;
				S_DRAW:   st_q <= rep_q ? S_REP_NEXT : S_FIN;
				S_JUDGE: begin
					cnt_q <= '0;
					if (dec.valid) begin
						attr_q <= dec.attr;
						esc_q  <= 1'b0;
						st_q   <= S_FIN;
					end else begin
						rep_n_q <= cnt_q;
						rep_i_q <= '0;
						rep_q   <= 1'b1;
						st_q    <= S_REP_RD;
					end
				end
				S_REP_RD: st_q <= S_REP_LD;
				S_REP_LD: begin
					ch_q  <= erd;
					byp_q <= 1'b1;
					st_q  <= S_PCHAR;
				end
				S_REP_NEXT: begin
					if (rep_i_q + ECW'(1) == rep_n_q) begin
						esc_q <= 1'b0;
						rep_q <= 1'b0;
						st_q  <= S_FIN;
					end else begin
						rep_i_q <= rep_i_q + ECW'(1);
						st_q    <= S_REP_RD;
					end
				end
				S_ER_A: begin
					if (c_q != '0) begin
						c_q  <= c_q - CW'(1);
						ph_q <= ph_dec;
					end else if (r_q != '0) begin
						r_q  <= r_q - RW'(1);
						c_q  <= CW'(SCREEN_COLUMNS - 1);
						ph_q <= PW'(LAST_PH);
					end
					st_q <= S_ER_B;
				end
				S_ER_B: begin
					if (twice_q) begin
						twice_q <= 1'b0;
						st_q    <= S_ER_A;
					end else begin
						st_q <= S_FIN;
					end
				end
				S_CLR: begin
					if (32'(k_q) == CELLS - 1) begin
						r_q  <= '0;
						c_q  <= '0;
						ph_q <= '0;
						st_q <= S_DRAW;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_RD:      st_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					cell_q <= ram_rd;
					st_q   <= S_FIN;
				end
				S_FIN: begin
					done_q               <= !quiet_q;
					rsp_q.cursor_row     <= 5'(r_q);
					rsp_q.cursor_column  <= 7'(c_q);
					rsp_q.attribute_word <= attr_q;
					rsp_q.escape_pending <= esc_q;
					rsp_q.cell_value     <= cell_q;
					st_q                 <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
	import tcsgr_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int TABW = 8;
	localparam int ESCD = 64;
	localparam int IDLE_LIMIT = 400000;
	localparam logic [3:0] PALETTE [8] = '{4'h0, 4'h4, 4'h2, 4'hE, 4'h1, 4'h5, 4'h3, 4'hF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	text_console_with_sgr_colour i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #6 clk = ~clk;

	// console shadow state
	logic [15:0] cells [ROWS*COLS];
	int          cur_row, cur_col;
	logic [15:0] attr;
	bit          esc_on;
	logic [7:0]  esc_buf [ESCD];
	int          esc_len;

	req_t pending_q [$];
	rsp_t expected_q [$];
	int   n_fail = 0, n_checked = 0, n_sgr = 0, n_bad_seq = 0;

	function automatic void set_cell(int r, int c, logic [15:0] v);
		if (r < ROWS && c < COLS) cells[r*COLS + c] = v;
	endfunction

	function automatic void print_char(logic [7:0] ch);
		int r, c, k;
		r = cur_row;
		c = cur_col;
		case (ch)
			CH_LF: r = r + 1;
			CH_CR: begin
				set_cell(r, c, 16'h0);
				cur_col = 0;
				return;
			end
			CH_TAB: c = (c / TABW + 1) * TABW;
			CH_ESC: ; // only reached while collecting: just redraw the cursor
			CH_BS, CH_DEL: return;
			default: begin
				set_cell(r, c, attr | {8'h0, ch});
				c = c + 1;
			end
		endcase
		if (c >= COLS) begin
			c = 0;
			r = r + 1;
		end
		if (r >= ROWS) begin
			for (k = 0; k < (ROWS-1)*COLS; k++) cells[k] = cells[k+COLS];
			for (k = (ROWS-1)*COLS; k < ROWS*COLS; k++) cells[k] = 16'h0;
			r = ROWS - 1;
		end
		cur_row = r;
		cur_col = c;
		set_cell(r, c, attr | {8'h0, CH_SPACE});
	endfunction

	function automatic bit apply_sgr();
		int code;
		if (esc_len == 4 && esc_buf[1] == CH_LBR && esc_buf[3] == CH_M) begin
			code = int'(esc_buf[2]) - int'(CH_ZERO);
			if (code == 0) attr = ATTR_DEFAULT;
			else if (code == 1) attr = attr | ATTR_BRIGHT;
			else return 1'b0;
			return 1'b1;
		end
		if (esc_len == 5 && esc_buf[1] == CH_LBR && esc_buf[4] == CH_M) begin
			code = (int'(esc_buf[2]) - int'(CH_ZERO)) * 10 + int'(esc_buf[3]) - int'(CH_ZERO);
			if (code >= 30 && code <= 37)
				attr = (attr & FG_KEEP) | {4'h0, PALETTE[code-30], 8'h0};
			else if (code >= 40 && code <= 47)
				attr = (attr & BG_KEEP) | {PALETTE[code-40], 12'h0};
			else return 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void collect_byte(logic [7:0] ch);
		logic [7:0] saved [ESCD];
		int n;
		if (esc_len < ESCD) begin
			esc_buf[esc_len] = ch;
			esc_len++;
		end
		if (ch != CH_M && esc_len < ESCD) return;
		if (apply_sgr()) begin
			esc_len = 0;
			esc_on = 1'b0;
			return;
		end
		// bad sequence: replay buffered bytes as text
		n = esc_len;
		saved = esc_buf;
		esc_len = 0;
		for (int i = 0; i < n; i++) print_char(saved[i]);
		esc_on = 1'b0;
	endfunction

	function automatic void blank_screen();
		foreach (cells[k]) cells[k] = 16'h0;
		cur_row = 0;
		cur_col = 0;
		cells[0] = attr | {8'h0, CH_SPACE};
	endfunction

	function automatic void erase_step();
		set_cell(cur_row, cur_col, 16'h0);
		if (cur_col != 0) cur_col--;
		else if (cur_row != 0) begin
			cur_row--;
			cur_col = COLS - 1;
		end
		set_cell(cur_row, cur_col, attr | {8'h0, CH_SPACE});
	endfunction

	function automatic rsp_t console_step(req_t t);
		rsp_t o;
		o.cell_value = 16'h0;
		case (t.req_type)
			REQ_PUT: begin
				if (esc_on && !t.bypass_escape) collect_byte(t.char_code);
				else if (t.char_code == CH_ESC && !esc_on) begin
					esc_on = 1'b1;
					collect_byte(t.char_code);
				end else print_char(t.char_code);
			end
			REQ_ERASE: begin
				erase_step();
				if (t.erase_twice) erase_step();
			end
			REQ_READ:
				if (t.query_row < ROWS && t.query_column < COLS)
					o.cell_value = cells[t.query_row*COLS + t.query_column];
			default: blank_screen();
		endcase
		o.cursor_row = cur_row[4:0];
		o.cursor_column = cur_col[6:0];
		o.attribute_word = attr;
		o.escape_pending = esc_on;
		return o;
	endfunction

	// driver: bursts and gaps, changes at the falling edge
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n || pending_q.size() == 0) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			req <= pending_q[0];
			if (burst_left > 0) burst_left--;
			else begin
				burst_left = $urandom_range(0, 30);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			end
		end
	end

	// monitor and transaction acceptance
	int idle_cycles = 0;
	always @(posedge clk) begin
		rsp_t e;
		if (done) begin
			n_checked++;
			if (expected_q.size() == 0) begin
				$error("unexpected transaction on result port");
				n_fail++;
			end else begin
				e = expected_q.pop_front();
				if (rsp.cursor_row !== e.cursor_row) begin
					$error("cursor_row exp %0d got %0d", e.cursor_row, rsp.cursor_row);
					n_fail++;
				end
				if (rsp.cursor_column !== e.cursor_column) begin
					$error("cursor_column exp %0d got %0d", e.cursor_column, rsp.cursor_column);
					n_fail++;
				end
				if (rsp.attribute_word !== e.attribute_word) begin
					$error("attribute_word exp %h got %h", e.attribute_word, rsp.attribute_word);
					n_fail++;
				end
				if (rsp.escape_pending !== e.escape_pending) begin
					$error("escape_pending exp %b got %b", e.escape_pending, rsp.escape_pending);
					n_fail++;
				end
				if (rsp.cell_value !== e.cell_value) begin
					$error("cell_value exp %h got %h", e.cell_value, rsp.cell_value);
					n_fail++;
				end
			end
		end
		if (arst_n && start && !busy && pending_q.size() != 0) begin
			expected_q.push_back(console_step(pending_q.pop_front()));
		end
		if (done || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void add_req(logic [1:0] kind, logic [7:0] ch, bit byp = 0,
			bit twice = 0, logic [4:0] qr = 0, logic [6:0] qc = 0);
		req_t t;
		t.req_type = kind;
		t.char_code = ch;
		t.bypass_escape = byp;
		t.erase_twice = twice;
		t.query_row = qr;
		t.query_column = qc;
		pending_q.push_back(t);
	endfunction

	function automatic void add_put(logic [7:0] ch, bit byp = 0);
		add_req(REQ_PUT, ch, byp, 1'($urandom_range(0, 1)), 5'($urandom), 7'($urandom));
	endfunction

	function automatic void add_sgr(int code);
		add_put(CH_ESC);
		add_put(CH_LBR);
		if (code >= 10) add_put(CH_ZERO + 8'(code / 10));
		add_put(CH_ZERO + 8'(code % 10));
		add_put(CH_M);
	endfunction

	int pick, code;
	initial begin
		attr = ATTR_DEFAULT;
		esc_on = 1'b0;
		esc_len = 0;
		blank_screen();

		// directed
		add_req(REQ_READ, 8'h00, 0, 0, 5'd0, 7'd0);
		add_req(REQ_ERASE, 8'hFF, 1, 1);          // top-left erase stays put
		add_put(8'h41);
		add_put(8'hFF);
		add_put(8'h00);
		add_put(CH_TAB);
		add_put(CH_BS);
		add_put(CH_DEL);
		add_put(CH_CR);
		add_put(CH_LF);
		add_sgr(31);
		add_sgr(47);
		add_sgr(1);
		add_put(8'h5A);
		add_sgr(0);
		add_put(CH_ESC); add_put(CH_LBR); add_put(CH_ESC, 1); add_put(8'h39); add_put(CH_M);
		add_req(REQ_READ, 8'h00, 0, 0, 5'd31, 7'd127);
		add_req(REQ_READ, 8'h00, 0, 0, 5'd24, 7'd79);
		add_req(REQ_CLEAR, 8'h00);

		// random: mostly SGR sequences and text, some broken sequences
		while (pending_q.size() < 520) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				code = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1) :
					($urandom_range(0, 1) ? $urandom_range(30, 37) : $urandom_range(40, 47));
				add_sgr(code);
				n_sgr++;
			end else if (pick < 31) begin
				n_bad_seq++;
				add_put(CH_ESC);
				if ($urandom_range(0, 7) == 0)
					repeat (ESCD + 2)
						add_put(8'($urandom_range(32, 108)), $urandom_range(0, 9) == 0);
				else begin
					repeat ($urandom_range(0, 5)) add_put(8'($urandom), $urandom_range(0, 3) == 0);
					add_put(CH_M);
				end
			end else if (pick < 66) begin
				add_put($urandom_range(0, 3) ? 8'($urandom_range(32, 126)) : 8'($urandom),
					$urandom_range(0, 9) == 0);
			end else if (pick < 74) begin
				case ($urandom_range(0, 5))
					0: add_put(CH_LF);
					1: add_put(CH_CR);
					2: add_put(CH_TAB);
					3: add_put(CH_BS);
					4: add_put(CH_DEL);
					default: add_put(CH_ESC, 1);
				endcase
			end else if (pick < 85) begin
				add_req(REQ_ERASE, 8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 5'($urandom), 7'($urandom));
			end else if (pick < 99) begin
				if ($urandom_range(0, 4) == 0)
					add_req(REQ_READ, 8'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 5'($urandom), 7'($urandom));
				else
					add_req(REQ_READ, 8'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 5'($urandom_range(0, ROWS-1)),
						7'($urandom_range(0, COLS-1)));
			end else begin
				add_req(REQ_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 5'($urandom), 7'($urandom));
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("checked %0d transactions: %0d SGR sequences, %0d malformed sequences",
			n_checked, n_sgr, n_bad_seq);
		$display("mismatches: %0d", n_fail);
		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
sv/tcsgr_pkg.sv
sv/tcsgr_cell_ram.sv
sv/tcsgr_esc_ram.sv
sv/tcsgr_sgr_decode.sv
sv/text_console_with_sgr_colour.sv
tb/testbench.sv
